// ===== hdl/tile_row_palette_expander_core_defines.svh =====
// assertion macros shared by the row expander
`ifndef TILE_ROW_PALETTE_EXPANDER_CORE_DEFINES_SVH
`define TILE_ROW_PALETTE_EXPANDER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/trpe_pkg.sv =====
`default_nettype none

package trpe_pkg;

    // request operations
    typedef enum logic [1:0] {
        OP_TILE_WRITE   = 2'd0,
        OP_COLOUR_WRITE = 2'd1,
        OP_EXPAND       = 2'd2,
        OP_NONE         = 2'd3
    } op_t;

    // fixed palette selections
    localparam logic [2:0] PAL_CGA  = 3'd4;
    localparam logic [2:0] PAL_GREY = 3'd5;

    localparam int TILE_ADDR_W    = 14;
    localparam int COLOUR_ENTRIES = 64;
    localparam int COLOUR_ADDR_W  = 6;
    localparam int LANES          = 8;

    localparam logic [23:0] GEN_WHITE  = 24'hE0E0E0;
    localparam logic [23:0] FULL_WHITE = 24'hFFFFFF;

    typedef logic [23:0] pixel_t;

    // colour memory write request broadcast to every lane
    typedef struct packed {
        logic                     en;
        logic [COLOUR_ADDR_W-1:0] addr;
        logic [15:0]              data;
    } colour_wr_t;

    // pixel position of each nibble, low nibble first
    localparam logic [2:0] NIBBLE_SLOT [LANES] = '{
        3'd3, 3'd2, 3'd1, 3'd0, 3'd7, 3'd6, 3'd5, 3'd4
    };

    // fixed cga colour table
    function automatic pixel_t cga_colour(input logic [3:0] nib);
        pixel_t c;
        case (nib)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'hAA0000;
            4'd2:    c = 24'h00AA00;
            4'd3:    c = 24'hAAAA00;
            4'd4:    c = 24'h0000AA;
            4'd5:    c = 24'hAA00AA;
            4'd6:    c = 24'h0055AA;
            4'd7:    c = 24'hAAAAAA;
            4'd8:    c = 24'h555555;
            4'd9:    c = 24'hFF5555;
            4'd10:   c = 24'h55FF55;
            4'd11:   c = 24'hFFFF55;
            4'd12:   c = 24'h5555FF;
            4'd13:   c = 24'hFF55FF;
            4'd14:   c = 24'h55FFFF;
            4'd15:   c = 24'hFFFFFF;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

    // colour entry decode with white lift
    function automatic pixel_t decode_entry(input logic [15:0] e);
        pixel_t c;
        c = {e[11:8], 4'h0, e[7:4], 4'h0, e[3:0], 4'h0};
        if (c == GEN_WHITE)
        begin
            c = FULL_WHITE;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/trpe_tile_mem.sv =====
`default_nettype none

module trpe_tile_mem
    import trpe_pkg::*;
#(
    parameter int TILE_WORDS = 16384
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [TILE_ADDR_W-1:0] wr_addr,
    input  wire logic [31:0]            wr_data,
    input  wire logic                   rd_en,
    input  wire logic [TILE_ADDR_W-1:0] rd_addr,
    output logic                        rd_valid,
    output logic [31:0]                 rd_word
);

    localparam int AW = $clog2(TILE_WORDS);
    localparam logic [TILE_ADDR_W:0] ADDR_LIMIT = (TILE_ADDR_W + 1)'(TILE_WORDS);

    logic [31:0] tile_mem [TILE_WORDS];
    logic [31:0] rd_data_reg;
    logic        rd_valid_reg;
    logic        rd_valid_next;
    logic        in_range_reg;
    logic        in_range_next;
    logic        wr_hit;
    logic        rd_hit;

    // addresses past the end of the store are dropped on write, zero on read
    assign wr_hit = wr_en && ({1'b0, wr_addr} < ADDR_LIMIT);
    assign rd_hit = rd_en && ({1'b0, rd_addr} < ADDR_LIMIT);

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            tile_mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_hit)
        begin
            rd_data_reg <= tile_mem[rd_addr[AW-1:0]];
        end
    end

    // read control
    always_comb
    begin
        rd_valid_next = rd_en;
        in_range_next = rd_en ? rd_hit : in_range_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            in_range_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_valid_next;
            in_range_reg <= in_range_next;
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_word  = in_range_reg ? rd_data_reg : 32'h0;

endmodule

`default_nettype wire

// ===== hdl/trpe_lane.sv =====
`default_nettype none

module trpe_lane
    import trpe_pkg::*;
(
    input  wire logic                      clk,
    input  wire colour_wr_t                colour_wr,
    input  wire logic [COLOUR_ENTRIES-1:0] entry_valid,
    input  wire logic                      rd_en,
    input  wire logic [3:0]                nibble,
    input  wire logic [2:0]                palette,
    output pixel_t                         colour
);

    logic [15:0]               colour_mem [COLOUR_ENTRIES];
    logic [15:0]               rd_data_reg;
    logic                      rd_hit_reg;
    logic [3:0]                nibble_reg;
    logic [COLOUR_ADDR_W-1:0]  rd_idx;
    logic [15:0]               entry;

    // palettes six and seven wrap onto lines two and three
    assign rd_idx = {palette[1:0], nibble};

    // local copy of the colour memory, written flags shared across lanes
    always_ff @(posedge clk)
    begin
        if (colour_wr.en)
        begin
            colour_mem[colour_wr.addr] <= colour_wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= colour_mem[rd_idx];
            rd_hit_reg  <= entry_valid[rd_idx];
            nibble_reg  <= nibble;
        end
    end

    // palette select
    assign entry = rd_hit_reg ? rd_data_reg : 16'h0;

    always_comb
    begin
        case (palette)
            PAL_CGA:  colour = cga_colour(nibble_reg);
            PAL_GREY: colour = {6{nibble_reg}};
            default:  colour = decode_entry(entry);
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/trpe_merge.sv =====
`default_nettype none

module trpe_merge
    import trpe_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   lane_valid,
    input  wire pixel_t lane_colour [LANES],
    output pixel_t      pixel [LANES],
    output logic        done
);

    pixel_t pixel_reg  [LANES];
    pixel_t pixel_next [LANES];
    logic   done_reg;

    // put each lane's colour in its screen position, the slot map is its own inverse
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            pixel_next[k] = lane_colour[NIBBLE_SLOT[k]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_valid)
        begin
            pixel_reg <= pixel_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= lane_valid;
        end
    end

    assign pixel = pixel_reg;
    assign done  = done_reg;

endmodule

`default_nettype wire

// ===== hdl/tile_row_palette_expander_core.sv =====
`default_nettype none
// Tile row palette expander.
// Requests enter on start while busy is low. Operation 0 writes a word of the tile
// memory, operation 1 writes an entry of the colour memory, operation 2 expands one
// eight-pixel row of a tile; operation 3 does nothing. Writes take effect at the
// accepting edge and leave busy low, so a write may be issued every cycle while no
// row is in flight. A row request raises busy through the tile memory read and then
// the colour memory read in the eight lanes. After the merge register, done is high
// for exactly one cycle with pixel_0..pixel_7 valid; the receiver cannot hold them.
// A new request may be accepted in that same cycle; a new row is not taken until the
// last one has passed both registered memory reads in series.
// The palette register is written over the cfg channel; cfg_ready is low while busy.
// Reset clears the palette choice to line 0 and makes every colour entry read as zero
// until written; tile words are undefined until written and need no clearing pass.
// Words beyond TILE_WORDS are dropped on write and read as zero.

`include "tile_row_palette_expander_core_defines.svh"

module tile_row_palette_expander_core
    import trpe_pkg::*;
#(
    parameter int TILE_WORDS = 16384
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [13:0] tile_word_address,
    input  wire logic [31:0] tile_word_data,
    input  wire logic [5:0]  colour_address,
    input  wire logic [15:0] colour_data,
    input  wire logic [10:0] tile_number,
    input  wire logic [2:0]  row_number,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_data,
    output logic             done,
    output logic [23:0]      pixel_0,
    output logic [23:0]      pixel_1,
    output logic [23:0]      pixel_2,
    output logic [23:0]      pixel_3,
    output logic [23:0]      pixel_4,
    output logic [23:0]      pixel_5,
    output logic [23:0]      pixel_6,
    output logic [23:0]      pixel_7
);

    logic       accept;
    logic       tile_wr_en;
    logic       expand_req;
    colour_wr_t colour_wr;
    logic       fetch_valid;
    logic [31:0] row_word;
    logic [2:0] palette_reg;
    logic [2:0] palette_next;
    logic       lane_valid_reg;
    logic [COLOUR_ENTRIES-1:0] entry_valid_reg;
    logic [COLOUR_ENTRIES-1:0] entry_valid_next;
    pixel_t     lane_colour [LANES];
    pixel_t     pixel [LANES];

    // request decode
    assign accept     = start && !busy;
    assign tile_wr_en = accept && (operation == OP_TILE_WRITE);
    assign expand_req = accept && (operation == OP_EXPAND);

    assign colour_wr.en   = accept && (operation == OP_COLOUR_WRITE);
    assign colour_wr.addr = colour_address;
    assign colour_wr.data = colour_data;

    assign busy      = fetch_valid || lane_valid_reg;
    assign cfg_ready = !busy;

    // palette register
    always_comb
    begin
        palette_next = palette_reg;
        if (cfg_valid && cfg_ready)
        begin
            palette_next = cfg_data;
        end
    end

    // colour entries not yet written read as zero
    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        if (colour_wr.en)
        begin
            entry_valid_next[colour_wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_reg     <= 3'd0;
            lane_valid_reg  <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            palette_reg     <= palette_next;
            lane_valid_reg  <= fetch_valid;
            entry_valid_reg <= entry_valid_next;
        end
    end

    // tile memory and row fetch
    trpe_tile_mem #(
        .TILE_WORDS (TILE_WORDS)
    ) u_tile_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tile_wr_en),
        .wr_addr  (tile_word_address),
        .wr_data  (tile_word_data),
        .rd_en    (expand_req),
        .rd_addr  ({tile_number, row_number}),
        .rd_valid (fetch_valid),
        .rd_word  (row_word)
    );

    // one palette lane per nibble
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        trpe_lane u_lane (
            .clk         (clk),
            .colour_wr   (colour_wr),
            .entry_valid (entry_valid_reg),
            .rd_en       (fetch_valid),
            .nibble      (row_word[4*k +: 4]),
            .palette     (palette_reg),
            .colour      (lane_colour[k])
        );
    end

    // reorder into screen positions and register the result
    trpe_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .lane_valid  (lane_valid_reg),
        .lane_colour (lane_colour),
        .pixel       (pixel),
        .done        (done)
    );

    assign pixel_0 = pixel[0];
    assign pixel_1 = pixel[1];
    assign pixel_2 = pixel[2];
    assign pixel_3 = pixel[3];
    assign pixel_4 = pixel[4];
    assign pixel_5 = pixel[5];
    assign pixel_6 = pixel[6];
    assign pixel_7 = pixel[7];

    // pipeline checks
    `ASSERT_NEXT(a_expand_fetch, clk, rst_n, expand_req, fetch_valid, "row request lost before fetch")
    `ASSERT_NEXT(a_fetch_lane, clk, rst_n, fetch_valid, lane_valid_reg, "fetch lost before lanes")
    `ASSERT_NEXT(a_lane_done, clk, rst_n, lane_valid_reg, done, "lane result not delivered")
    `ASSERT_IMPLY(a_one_in_flight, clk, rst_n, fetch_valid, !lane_valid_reg, "two rows in flight")

endmodule

`default_nettype wire

// ===== verif/row_expand_check_pkg.sv =====
`timescale 1ns / 1ps

package row_expand_check_pkg;

    import trpe_pkg::*;

    // one request as presented on the input ports
    typedef struct {
        op_t         op;
        logic [13:0] waddr;
        logic [31:0] wdata;
        logic [5:0]  caddr;
        logic [15:0] cdata;
        logic [10:0] tile;
        logic [2:0]  row;
    } req_t;

    // eight pixels, index k is pixel_k
    typedef logic [7:0][23:0] pixel_row_t;

    class row_scoreboard;

        bit [31:0]  tile_mem [16384];
        bit         tile_seen [16384];
        int         tile_written [$];
        bit [15:0]  colour_mem [64];
        bit [2:0]   palette_sel;
        bit [23:0]  cga_rgb [16];
        pixel_row_t expected_rows [$];
        int         errors;

        function new();
            cga_rgb = '{24'h000000, 24'hAA0000, 24'h00AA00, 24'hAAAA00,
                        24'h0000AA, 24'hAA00AA, 24'h0055AA, 24'hAAAAAA,
                        24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
                        24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF};
            palette_sel = 3'd0;
            errors = 0;
        endfunction

        function void set_palette(bit [2:0] v);
            palette_sel = v;
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction

        // colour of one nibble under the current palette
        function bit [23:0] colour_of(bit [3:0] nib);
            bit [15:0] e;
            bit [23:0] c;
            if (palette_sel == PAL_CGA)
            begin
                return cga_rgb[nib];
            end
            if (palette_sel == PAL_GREY)
            begin
                return {nib, nib, nib, nib, nib, nib};
            end
            // choices six and seven wrap onto lines two and three
            e = colour_mem[{palette_sel[1:0], nib}];
            c = {e[11:8], 4'h0, e[7:4], 4'h0, e[3:0], 4'h0};
            if (c == 24'hE0E0E0)
            begin
                c = 24'hFFFFFF;
            end
            return c;
        endfunction

        // update the memories for an accepted request, queue a row if one is due
        function void note_request(req_t r);
            pixel_row_t px;
            bit [13:0]  a;
            bit [31:0]  w;
            case (r.op)
                OP_TILE_WRITE:
                begin
                    if (!tile_seen[r.waddr])
                    begin
                        tile_written.push_back(int'(r.waddr));
                    end
                    tile_seen[r.waddr] = 1'b1;
                    tile_mem[r.waddr] = r.wdata;
                end
                OP_COLOUR_WRITE:
                begin
                    colour_mem[r.caddr] = r.cdata;
                end
                OP_EXPAND:
                begin
                    a = {r.tile, r.row};
                    w = tile_mem[a];
                    // low nibble first lands on pixel 3, slot is nibble index xor 3
                    for (int k = 0; k < 8; k++)
                    begin
                        px[k ^ 3] = colour_of(w[4*k +: 4]);
                    end
                    expected_rows.push_back(px);
                end
                default:
                begin
                end
            endcase
        endfunction

        // compare a delivered row with the oldest expected one
        function void check_row(pixel_row_t got);
            pixel_row_t exp_row;
            if (expected_rows.size() == 0)
            begin
                errors++;
                $display("%0t: row with none expected, got %h", $time, got);
                return;
            end
            exp_row = expected_rows.pop_front();
            for (int k = 0; k < 8; k++)
            begin
                if (got[k] !== exp_row[k])
                begin
                    errors++;
                    $display("%0t: pixel_%0d expected %06h got %06h",
                             $time, k, exp_row[k], got[k]);
                end
            end
        endfunction

    endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import trpe_pkg::*;
    import row_expand_check_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    op_t         operation;
    logic [13:0] tile_word_address;
    logic [31:0] tile_word_data;
    logic [5:0]  colour_address;
    logic [15:0] colour_data;
    logic [10:0] tile_number;
    logic [2:0]  row_number;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;
    logic        done;
    logic [23:0] pixel_0;
    logic [23:0] pixel_1;
    logic [23:0] pixel_2;
    logic [23:0] pixel_3;
    logic [23:0] pixel_4;
    logic [23:0] pixel_5;
    logic [23:0] pixel_6;
    logic [23:0] pixel_7;

    row_scoreboard sb = new();
    int            sender_idle_pct;

    tile_row_palette_expander_core DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .operation         (operation),
        .tile_word_address (tile_word_address),
        .tile_word_data    (tile_word_data),
        .colour_address    (colour_address),
        .colour_data       (colour_data),
        .tile_number       (tile_number),
        .row_number        (row_number),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .done              (done),
        .pixel_0           (pixel_0),
        .pixel_1           (pixel_1),
        .pixel_2           (pixel_2),
        .pixel_3           (pixel_3),
        .pixel_4           (pixel_4),
        .pixel_5           (pixel_5),
        .pixel_6           (pixel_6),
        .pixel_7           (pixel_7)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result monitor, done is a one-cycle strobe
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_row({pixel_7, pixel_6, pixel_5, pixel_4,
                          pixel_3, pixel_2, pixel_1, pixel_0});
        end
    end

    // present one request and hold it until accepted
    task automatic issue(input req_t r);
        int gap;
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start             <= 1'b1;
        operation         <= r.op;
        tile_word_address <= r.waddr;
        tile_word_data    <= r.wdata;
        colour_address    <= r.caddr;
        colour_data       <= r.cdata;
        tile_number       <= r.tile;
        row_number        <= r.row;
        do @(posedge clk); while (busy);
        sb.note_request(r);
    endtask

    // request with every field random, operation fixed by the caller
    function automatic req_t noise_request(input op_t op);
        req_t r;
        r.op    = op;
        r.waddr = 14'($urandom);
        r.wdata = $urandom;
        r.caddr = 6'($urandom);
        r.cdata = 16'($urandom);
        r.tile  = 11'($urandom);
        r.row   = 3'($urandom);
        return r;
    endfunction

    task automatic tile_write(input logic [13:0] a, input logic [31:0] d);
        req_t r;
        r = noise_request(OP_TILE_WRITE);
        r.waddr = a;
        r.wdata = d;
        issue(r);
    endtask

    task automatic colour_write(input logic [5:0] a, input logic [15:0] d);
        req_t r;
        r = noise_request(OP_COLOUR_WRITE);
        r.caddr = a;
        r.cdata = d;
        issue(r);
    endtask

    task automatic expand_row(input logic [13:0] a);
        req_t r;
        r = noise_request(OP_EXPAND);
        r.tile = a[13:3];
        r.row  = a[2:0];
        issue(r);
    endtask

    // mixed traffic, row reads only of words already written
    function automatic req_t random_request();
        req_t        r;
        int          pick;
        int          n;
        logic [13:0] a;
        pick = $urandom_range(0, 99);
        n = sb.tile_written.size();
        if (pick < 5)
        begin
            r = noise_request(OP_NONE);
        end
        else if (pick < 25)
        begin
            r = noise_request(OP_COLOUR_WRITE);
            // now and then an entry that decodes to the white that is lifted
            if ($urandom_range(0, 9) == 0)
            begin
                r.cdata = {4'($urandom), 12'hEEE};
            end
        end
        else if (pick < 55 || n == 0)
        begin
            r = noise_request(OP_TILE_WRITE);
        end
        else
        begin
            r = noise_request(OP_EXPAND);
            a = 14'(sb.tile_written[$urandom_range(0, n - 1)]);
            r.tile = a[13:3];
            r.row  = a[2:0];
        end
        return r;
    endfunction

    // palette register write once the block has drained
    task automatic set_palette_reg(input logic [2:0] v);
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_palette(v);
    endtask

    // stimulus
    initial
    begin
        int pal_seq [9];
        pal_seq = '{3'd0, 3'd7, 3'd4, 3'd5, 3'd1, 3'd6, 3'd2, 3'd3, 3'd5};
        rst_n             = 1'b0;
        start             = 1'b0;
        operation         = OP_TILE_WRITE;
        tile_word_address = '0;
        tile_word_data    = '0;
        colour_address    = '0;
        colour_data       = '0;
        tile_number       = '0;
        row_number        = '0;
        cfg_valid         = 1'b0;
        cfg_data          = '0;
        sender_idle_pct   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, white lift, nibble order, ignored operation
        set_palette_reg(3'd0);
        colour_write(6'd0, 16'h0EEE);
        colour_write(6'd1, 16'hFEEE);
        colour_write(6'd15, 16'hFFFF);
        colour_write(6'd63, 16'hFFFF);
        colour_write(6'd48, 16'h0EEE);
        tile_write(14'd0, 32'h76543210);
        tile_write(14'd16383, 32'hFFFFFFFF);
        tile_write(14'd1, 32'h00000000);
        tile_write(14'h2AAA, 32'hFEDCBA98);
        expand_row(14'd0);
        expand_row(14'd16383);
        expand_row(14'd1);
        expand_row(14'h2AAA);
        issue(noise_request(OP_NONE));
        set_palette_reg(3'd3);
        expand_row(14'd16383);
        expand_row(14'd0);
        set_palette_reg(3'd4);
        expand_row(14'h2AAA);
        expand_row(14'd0);
        set_palette_reg(3'd5);
        expand_row(14'h2AAA);
        set_palette_reg(3'd7);
        expand_row(14'd16383);

        // random phases, palette changed between them
        for (int c = 0; c < 9; c++)
        begin
            sender_idle_pct = (c < 3) ? 15 : ((c < 6) ? 46 : 0);
            set_palette_reg(3'(pal_seq[c]));
            repeat (150) issue(random_request());
        end

        // drain
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
